/* hdl/msl_pkg.sv */
// ----------------------------------------------------------------------------
// msl_pkg
// shared constants, codes and types for the save list table
// ----------------------------------------------------------------------------
package msl_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int OP_W        = 2;
   localparam int KEY_W       = 32;
   localparam int DATA_W      = 64;
   localparam int STAT_W      = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC,
      S_FINISH
   } fsm_state_type;

   // controller to datapath
   typedef struct packed {
      logic start;   // capture request, clear search
      logic scan;    // step the search
      logic exec;    // apply the operation
      logic load;    // move result into the response register
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic found;      // compare stage hit
      logic exhausted;  // all filled entries searched
      logic rsp_free;   // response register can take a beat
   } dp_stat_type;

endpackage

/* hdl/msr_save_list_table.sv */
// ----------------------------------------------------------------------------
// msr_save_list_table
// associative table of register index / 64-bit data pairs, filled in order
// ----------------------------------------------------------------------------
// one request is handled at a time. after a request beat is taken the filled
// entries are searched from entry 0 upward, one entry per clock through the
// registered read port of the index store. a request that misses searches
// every filled entry (none on an empty table, all 256 on a full table), and
// a hit at entry k stops the search there. the result is then applied in an
// execute step and moved into the response register. the next request beat
// is taken in the cycle after the response is loaded, so a miss on a full
// table holds the request channel through its whole search of the index
// store. read returns the data of the matching entry, write replaces it, add
// appends the index with zeroed data unless it is already present or the
// table is full. the response sits in an output register, so the next
// request beat is taken while a finished response still waits on rsp_stall.
// the stores are not cleared at reset; only entries below the fill count are
// ever read.
// ----------------------------------------------------------------------------
module msr_save_list_table import msl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [KEY_W-1:0]    req_msr_index,
   input  logic [DATA_W-1:0]   req_write_data,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic [CNT_W-1:0]    rsp_fill_count
);

   ctl_cmd_type cmd;   // sequencer commands
   dp_stat_type stat;  // search and response status

   // sequencer: idle, search, execute, respond
   msl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // stores, search pipeline and response register
   msl_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_operation  (req_operation),
      .req_msr_index  (req_msr_index),
      .req_write_data (req_write_data),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule

/* hdl/msl_ctrl.sv */
// ----------------------------------------------------------------------------
// msl_ctrl
// request sequencer: accept, search, execute, respond
// ----------------------------------------------------------------------------
module msl_ctrl import msl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   fsm_state_type state_ff;
   fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.found || stat.exhausted) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
         end
         S_FINISH: begin
            cmd.load = stat.rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

/* hdl/msl_dpath.sv */
// ----------------------------------------------------------------------------
// msl_dpath
// index and data stores, sequential search, response register
// ----------------------------------------------------------------------------
module msl_dpath import msl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [KEY_W-1:0]    req_msr_index,
   input  logic [DATA_W-1:0]   req_write_data,
   input  ctl_cmd_type         cmd,
   output dp_stat_type         stat,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic [CNT_W-1:0]    rsp_fill_count
);

   logic [KEY_W-1:0]  key_mem [MAX_ENTRIES];
   logic [DATA_W-1:0] data_mem [MAX_ENTRIES];

   // captured request
   logic [OP_W-1:0]   op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] wdata_ff;

   // search state
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [KEY_W-1:0]  rd_key_ff;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0] rd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [CNT_W-1:0]  rsp_fill_ff;

   logic              found, exhausted, more, issue, full;
   logic              is_read, is_write, is_add;
   logic              data_re, data_we, append;
   logic [IDX_W-1:0]  data_wa;
   logic [DATA_W-1:0] data_wd;

   assign is_read  = (op_ff == OP_READ);
   assign is_write = (op_ff == OP_WRITE);
   assign is_add   = (op_ff == OP_ADD);
   assign full     = (cnt_ff == CNT_W'(MAX_ENTRIES));

   // search pipeline: issue address, then compare registered key
   assign more      = (ptr_ff < cnt_ff);
   assign found     = cmp_vld_ff && (rd_key_ff == key_ff);
   assign exhausted = !cmp_vld_ff && !more;
   assign issue     = cmd.scan && more && !found;

   assign cmp_vld_in = issue;
   assign ptr_in     = cmd.start ? '0 : (issue ? ptr_ff + 1'b1 : ptr_ff);
   assign rd_addr_in = issue ? ptr_ff[IDX_W-1:0] : rd_addr_ff;
   assign hit_in     = cmd.start ? 1'b0 : ((cmd.scan && found) ? 1'b1 : hit_ff);
   assign pos_in     = (cmd.scan && found) ? rd_addr_ff : pos_ff;

   // execute
   assign data_re = cmd.exec && is_read && hit_ff;
   assign append  = cmd.exec && is_add && !hit_ff && !full;
   assign data_we = (cmd.exec && is_write && hit_ff) || append;
   assign data_wa = append ? cnt_ff[IDX_W-1:0] : pos_ff;
   assign data_wd = append ? '0 : wdata_ff;
   assign cnt_in  = append ? cnt_ff + 1'b1 : cnt_ff;

   always_comb begin
      status_in = status_ff;
      if (cmd.exec) begin
         case (op_ff)
            OP_READ, OP_WRITE: status_in = hit_ff ? ST_OK : ST_MISSING;
            OP_ADD:            status_in = (hit_ff || !full) ? ST_OK : ST_FULL;
            default:           status_in = ST_MISSING;
         endcase
      end
   end

   assign rsp_valid_in = cmd.load || (rsp_valid_ff && rsp_stall);

   assign stat.found     = found;
   assign stat.exhausted = exhausted;
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_vld_ff   <= cmp_vld_in;
         hit_ff       <= hit_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= req_operation;
         key_ff   <= req_msr_index;
         wdata_ff <= req_write_data;
      end
      ptr_ff     <= ptr_in;
      rd_addr_ff <= rd_addr_in;
      pos_ff     <= pos_in;
      status_ff  <= status_in;
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= (is_read && hit_ff) ? rd_data_ff : '0;
         rsp_fill_ff   <= cnt_ff;
      end
   end

   // index store
   always_ff @(posedge clock) begin
      if (append) key_mem[cnt_ff[IDX_W-1:0]] <= key_ff;
      if (issue) rd_key_ff <= key_mem[ptr_ff[IDX_W-1:0]];
   end

   // data store
   always_ff @(posedge clock) begin
      if (data_we) data_mem[data_wa] <= data_wd;
      if (data_re) rd_data_ff <= data_mem[pos_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_fill_count = rsp_fill_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above capacity");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(cnt_ff)) |-> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("entry count moved by other than one");

   a_cmp_filled: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> ({1'b0, rd_addr_ff} < cnt_ff))
      else $error("compare on unfilled entry");

   a_hit_filled: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> ({1'b0, pos_ff} < cnt_ff))
      else $error("hit position beyond fill count");

endmodule
